FILE: design/bcpc_pkg.sv
package bcpc_pkg;

  // Field widths of one timestamp beat and one result beat.
  localparam int STAMP_W = 31;
  localparam int COUNT_W = 63;
  localparam int TOTAL_W = 7;

  // Default sizing of the two stamp banks and the group counter.
  localparam int DEF_MAX_GROUP_STAMPS = 256;
  localparam int DEF_MAX_GROUPS       = 64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;   // capture the accepted timestamp beat
    logic pop;     // consume the head entry of the previous list
    logic finish;  // add, push, and close group or bundle as flagged
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic avail;       // previous list still has entries to look at
    logic head_ready;  // head entry data is valid this cycle
    logic head_less;   // head stamp is strictly earlier than the current stamp
    logic out_block;   // result register cannot take a bundle's result this cycle
  } status_t;

endpackage

FILE: design/bcpc_ifs.sv
interface bcpc_in_if;
  import bcpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] stamp;
  logic               group_end;
  logic               bundle_end;

  modport source (output valid, output stamp, output group_end, output bundle_end,
                  input ready);
  modport sink   (input valid, input stamp, input group_end, input bundle_end,
                  output ready);
endinterface

interface bcpc_out_if;
  import bcpc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] path_count;
  logic [TOTAL_W-1:0] group_total;

  modport source (output valid, output path_count, output group_total, input ready);
  modport sink   (input valid, input path_count, input group_total, output ready);
endinterface

FILE: design/bcpc_ctrl.sv
module bcpc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bcpc_pkg::status_t sts,
  output bcpc_pkg::cmd_t    cmd
);
  import bcpc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CMP  = 1'b1;

  logic state;
  logic state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.avail && !sts.head_ready) begin
          // Wait for the head entry to come out of the bank.
        end else if (sts.avail && sts.head_less) begin
          cmd.pop = 1'b1;
        end else if (!sts.out_block) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A pop needs an entry left in the list and valid head data earlier than the current stamp.
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (sts.avail && sts.head_ready && sts.head_less))
    else $error("pop issued without a valid earlier head entry");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> !in_ready)
    else $error("input ready while a timestamp is in progress");

  a_finish_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (state == ST_IDLE))
    else $error("controller did not return to idle after finishing");

endmodule

FILE: design/bcpc_datapath.sv
module bcpc_datapath #(
  parameter int MAX_GROUP_STAMPS = bcpc_pkg::DEF_MAX_GROUP_STAMPS,
  parameter int MAX_GROUPS       = bcpc_pkg::DEF_MAX_GROUPS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bcpc_pkg::cmd_t               cmd,
  output bcpc_pkg::status_t            sts,
  input  logic [bcpc_pkg::STAMP_W-1:0] stamp,
  input  logic                         group_end,
  input  logic                         bundle_end,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [bcpc_pkg::COUNT_W-1:0] path_count,
  output logic [bcpc_pkg::TOTAL_W-1:0] group_total
);
  import bcpc_pkg::*;

  localparam int IW    = $clog2(MAX_GROUP_STAMPS + 1);
  localparam int AW    = (MAX_GROUP_STAMPS > 1) ? $clog2(MAX_GROUP_STAMPS) : 1;
  localparam int GW    = $clog2(MAX_GROUPS + 1);
  localparam int DEPTH = 2 * (2 ** AW);
  localparam int WORD_W = STAMP_W + COUNT_W;

  // Latched timestamp beat.
  logic [STAMP_W-1:0] ts_q;
  logic               gend_q;
  logic               bend_q;

  // List walking state.
  logic               active_bank;
  logic               start_list;
  logic [IW-1:0]      read_index;
  logic [IW-1:0]      prev_length;
  logic [IW-1:0]      write_index;
  logic [COUNT_W-1:0] last_popped;
  logic [COUNT_W-1:0] running_sum;
  logic               multi_seen;
  logic [GW-1:0]      group_counter;
  logic               head_ok;

  // Bank memory: both banks, stamp and cumulative count in one word.
  logic [WORD_W-1:0]  bank_mem [DEPTH];
  logic [WORD_W-1:0]  rd_word;
  logic [AW:0]        raddr;
  logic [AW:0]        waddr;
  logic [STAMP_W-1:0] head_stamp;
  logic [COUNT_W-1:0] head_count;

  // Finish arithmetic.
  logic [COUNT_W:0]   sum_wide;
  logic [COUNT_W-1:0] sum;
  logic               room;
  logic [IW-1:0]      wi_new;
  logic               multi_new;
  logic               close_group;
  logic [GW-1:0]      gc_new;
  logic [GW+TOTAL_W-1:0] gc_ext;

  assign raddr      = {~active_bank, read_index[AW-1:0]};
  assign waddr      = {active_bank, write_index[AW-1:0]};
  assign head_stamp = rd_word[WORD_W-1 -: STAMP_W];
  assign head_count = rd_word[COUNT_W-1:0];

  // The start list is one virtual entry that is earlier than any stamp, count one.
  assign sts.avail      = read_index < prev_length;
  assign sts.head_ready = start_list || head_ok;
  assign sts.head_less  = start_list || (head_stamp < ts_q);
  assign sts.out_block  = bend_q && out_valid && !out_ready;

  assign sum_wide    = {1'b0, running_sum} + {1'b0, last_popped};
  assign sum         = sum_wide[COUNT_W] ? COUNT_MAX : sum_wide[COUNT_W-1:0];
  assign room        = write_index < IW'(MAX_GROUP_STAMPS);
  assign wi_new      = room ? write_index + IW'(1) : write_index;
  assign multi_new   = multi_seen || (wi_new > IW'(1));
  assign close_group = gend_q || bend_q;
  assign gc_new      = (group_counter < GW'(MAX_GROUPS)) ? group_counter + GW'(1)
                                                         : group_counter;
  assign gc_ext      = {{TOTAL_W{1'b0}}, gc_new};

  // Bank read port, data registered.
  always_ff @(posedge clk) begin
    rd_word <= bank_mem[raddr];
  end

  // Bank write port: push the new entry unless the group is full.
  always_ff @(posedge clk) begin
    if (cmd.finish && room) begin
      bank_mem[waddr] <= {ts_q, sum};
    end
  end

  // Timestamp beat capture.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ts_q   <= stamp;
      gend_q <= group_end;
      bend_q <= bundle_end;
    end
  end

  // The read register matches the current head once it has been loaded from an unchanged address.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ok <= 1'b0;
    end else begin
      head_ok <= !(cmd.pop || (cmd.finish && close_group));
    end
  end

  // List state, sums and group count.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank   <= 1'b0;
      start_list    <= 1'b1;
      read_index    <= '0;
      prev_length   <= IW'(1);
      write_index   <= '0;
      last_popped   <= '0;
      running_sum   <= '0;
      multi_seen    <= 1'b0;
      group_counter <= '0;
    end else if (cmd.pop) begin
      last_popped <= start_list ? COUNT_W'(1) : head_count;
      read_index  <= read_index + IW'(1);
    end else if (cmd.finish) begin
      if (bend_q) begin
        active_bank   <= 1'b0;
        start_list    <= 1'b1;
        read_index    <= '0;
        prev_length   <= IW'(1);
        write_index   <= '0;
        last_popped   <= '0;
        running_sum   <= '0;
        multi_seen    <= 1'b0;
        group_counter <= '0;
      end else if (gend_q) begin
        active_bank   <= ~active_bank;
        start_list    <= 1'b0;
        read_index    <= '0;
        prev_length   <= wi_new;
        write_index   <= '0;
        last_popped   <= '0;
        running_sum   <= '0;
        multi_seen    <= multi_new;
        group_counter <= gc_new;
      end else begin
        write_index <= wi_new;
        running_sum <= sum;
        multi_seen  <= multi_new;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && bend_q) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && bend_q) begin
      path_count  <= multi_new ? sum : COUNT_W'(1);
      group_total <= gc_ext[TOTAL_W-1:0];
    end
  end

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (read_index <= prev_length) && (prev_length <= IW'(MAX_GROUP_STAMPS)))
    else $error("read index ran past the previous list");

  a_write_bound: assert property (@(posedge clk) disable iff (rst)
    write_index <= IW'(MAX_GROUP_STAMPS))
    else $error("write index ran past the bank");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && bend_q) |=> (out_valid && start_list && (write_index == '0)))
    else $error("bundle end did not load a result and restart");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && bend_q) |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule

FILE: design/bundled_cycle_path_counter_top.sv
// Counts the strictly time-increasing paths through a bundle of timestamp
// groups. Timestamps arrive one per beat, ascending within a group, with
// group_end on the last beat of a group and bundle_end on the last beat of the
// bundle; one result beat (path count and number of groups) follows each
// bundle end. Each timestamp is compared against the head entries of the previous
// group and pops those that are earlier; after each pop, the registered data of
// the single read port of the bank memory must settle before the next compare,
// except after a pop which empties the previous list (the start entry included).
// A bundle end also waits while the previous result is still unread. No clearing
// pass is needed after reset. A finished result waits in an output register while
// the next timestamps are taken in.
module bundled_cycle_path_counter_top #(
  parameter int MAX_GROUP_STAMPS = bcpc_pkg::DEF_MAX_GROUP_STAMPS,
  parameter int MAX_GROUPS       = bcpc_pkg::DEF_MAX_GROUPS
) (
  input logic         clk,
  input logic         rst,
  bcpc_in_if.sink     items,
  bcpc_out_if.source  results
);
  import bcpc_pkg::*;

  cmd_t    cmd;
  status_t sts;

  bcpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bcpc_datapath #(
    .MAX_GROUP_STAMPS (MAX_GROUP_STAMPS),
    .MAX_GROUPS       (MAX_GROUPS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .stamp       (items.stamp),
    .group_end   (items.group_end),
    .bundle_end  (items.bundle_end),
    .out_ready   (results.ready),
    .out_valid   (results.valid),
    .path_count  (results.path_count),
    .group_total (results.group_total)
  );

endmodule
